// ===== src/gost_pkg.sv =====
// Shared types, codes and round functions for the GOST cipher block.
`default_nettype none
package gost_pkg;

    typedef enum logic [3:0] {
        OP_ECB_ENC  = 4'd0,
        OP_ECB_DEC  = 4'd1,
        OP_GAMMA    = 4'd2,
        OP_CFB_ENC  = 4'd3,
        OP_CFB_DEC  = 4'd4,
        OP_MAC      = 4'd5,
        OP_GSYNC    = 4'd6,
        OP_CSYNC    = 4'd7,
        OP_MAC_INIT = 4'd8,
        OP_SBOX_ROW = 4'd9
    } opcode_t;

    typedef enum logic [2:0] {
        REG_KEY01 = 3'd0,
        REG_KEY23 = 3'd1,
        REG_KEY45 = 3'd2,
        REG_KEY67 = 3'd3,
        REG_BSWAP = 3'd4,
        REG_PAD   = 3'd5
    } cfg_index_t;

    // Cipher run kinds
    typedef enum logic [1:0] {
        RUN_ENC = 2'd0,
        RUN_DEC = 2'd1,
        RUN_MAC = 2'd2
    } run_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    localparam logic [31:0] C0 = 32'h0101_0101;
    localparam logic [31:0] C1 = 32'h0101_0104;

    // One classified item handed from the front to the back
    typedef struct packed {
        logic [3:0]  op;
        logic        active;
        logic [63:0] data;
        logic [63:0] mask;
        logic [3:0]  cnt;
        logic [2:0]  row;
    } cmd_t;

    function automatic logic [31:0] bswap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [63:0] swap_bytes(input logic [63:0] b, input logic en);
        return en ? {bswap32(b[63:32]), bswap32(b[31:0])} : b;
    endfunction

    function automatic logic [2:0] key_index(input run_t run, input logic [4:0] r);
        logic [2:0] k;
        k = r[2:0];
        if (run == RUN_ENC && r >= 5'd24)
            k = ~r[2:0];
        else if (run == RUN_DEC && r >= 5'd8)
            k = ~r[2:0];
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== src/gost_front.sv =====
// Front end: accepts items, saturates the count and builds the byte mask.
`default_nettype none
module gost_front
    import gost_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             ready,
    input  wire logic [3:0]  opcode,
    input  wire logic [63:0] block_in,
    input  wire logic [3:0]  byte_count,
    input  wire logic [2:0]  row_index,
    output logic             q_valid,
    input  wire logic        q_ready,
    output cmd_t             q_cmd
);
    // Two-entry queue
    cmd_t       mem_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    cmd_t       c;
    logic [3:0] n;
    logic       push;
    logic       pop;

    always_comb
    begin
        n = (byte_count > 4'd8) ? 4'd8 : byte_count;
        c.op = opcode;
        c.cnt = n;
        c.row = row_index;
        c.data = block_in;
        c.mask = (n == 4'd8) ? '1 : ((64'd1 << {n, 3'b000}) - 64'd1);
        c.active = (opcode <= 4'd5) && (n != 4'd0);
    end

    assign ready   = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = mem_reg[rp_reg];
    assign push    = valid && ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== src/gost_back.sv =====
// Back end: runs one cipher round a cycle and holds keys, S-box and chaining state.
`default_nettype none
module gost_back
    import gost_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire cmd_t        q_cmd,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      block_out,
    output logic [3:0]       valid_bytes
);
    logic [63:0] key_reg [4];
    logic        bswap_reg;
    logic [7:0]  pad_reg;
    logic [63:0] sbox_reg [8];
    logic [63:0] sync_reg;
    logic [63:0] mac_reg;

    state_t      state_reg, state_next;
    cmd_t        cmd_reg;
    run_t        run_reg;
    logic [4:0]  rnd_reg;
    logic [31:0] n1_reg, n2_reg;
    logic [63:0] res_reg;
    logic [3:0]  vb_reg;
    logic        ovalid_reg;

    logic [2:0]  ki;
    logic [31:0] kw, s, t, f, x;
    logic        last;
    logic [63:0] ci;
    logic [63:0] pad64, blk, g;
    logic [31:0] gn1, gn2;
    logic [32:0] gsum;
    logic        take;

    assign cfg_ready   = 1'b1;
    assign out_valid   = ovalid_reg;
    assign block_out   = res_reg;
    assign valid_bytes = vb_reg;
    assign q_ready     = (state_reg == ST_IDLE) && !ovalid_reg;
    assign take        = q_valid && q_ready;

    // Round datapath
    always_comb
    begin
        ki = key_index(run_reg, rnd_reg);
        kw = ki[0] ? key_reg[ki[2:1]][63:32] : key_reg[ki[2:1]][31:0];
        s  = n1_reg + kw;
        for (int j = 0; j < 8; j++)
            t[4*j +: 4] = sbox_reg[j][{s[4*j +: 4], 2'b00} +: 4];
        f  = {t[20:0], t[31:21]};
        x  = n2_reg ^ f;
        last = (run_reg == RUN_MAC) ? (rnd_reg == 5'd15) : (rnd_reg == 5'd31);
        ci = (run_reg == RUN_MAC) ? {n1_reg, x} : {x, n1_reg};
    end

    // Starting block for each opcode
    always_comb
    begin
        pad64 = {8{pad_reg}};
        blk   = (q_cmd.data & q_cmd.mask) | (pad64 & ~q_cmd.mask);
        gsum  = {1'b0, sync_reg[63:32]} + {1'b0, C1};
        gn1   = sync_reg[31:0] + C0;
        gn2   = gsum[31:0] + {31'd0, gsum[32]};
        g     = swap_bytes(ci, bswap_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take && (q_cmd.active || q_cmd.op == OP_GSYNC))
                state_next = ST_RUN;
            ST_RUN:  if (last)
                state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            bswap_reg  <= 1'b1;
            pad_reg    <= 8'd0;
            sync_reg   <= '0;
            mac_reg    <= '0;
            for (int i = 0; i < 4; i++)
                key_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_KEY01, REG_KEY23, REG_KEY45, REG_KEY67:
                        key_reg[cfg_index[1:0]] <= cfg_data;
                    REG_BSWAP: bswap_reg <= cfg_data[0];
                    REG_PAD:   pad_reg   <= cfg_data[7:0];
                    default:   ;
                endcase
            end
            if (take)
            begin
                case (q_cmd.op)
                    OP_GAMMA:
                        if (q_cmd.active)
                            sync_reg <= {gn2, gn1};
                    OP_CSYNC:    sync_reg <= {q_cmd.data[31:0], q_cmd.data[63:32]};
                    OP_MAC_INIT: mac_reg  <= q_cmd.data;
                    default:     ;
                endcase
                if (!(q_cmd.active || q_cmd.op == OP_GSYNC))
                    ovalid_reg <= 1'b1;
            end
            if (state_reg == ST_RUN && last)
            begin
                ovalid_reg <= 1'b1;
                case (cmd_reg.op)
                    OP_GSYNC: sync_reg <= ci;
                    OP_CFB_ENC:
                        sync_reg <= swap_bytes((g & ~cmd_reg.mask)
                            | ((cmd_reg.data ^ g) & cmd_reg.mask), bswap_reg);
                    OP_CFB_DEC:
                        sync_reg <= swap_bytes((g & ~cmd_reg.mask)
                            | (cmd_reg.data & cmd_reg.mask), bswap_reg);
                    OP_MAC:  mac_reg <= ci;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= q_cmd;
            rnd_reg <= 5'd0;
            res_reg <= '0;
            vb_reg  <= q_cmd.active ? q_cmd.cnt : 4'd0;
            if (q_cmd.op == OP_SBOX_ROW)
                sbox_reg[q_cmd.row] <= q_cmd.data;
            run_reg <= (q_cmd.op == OP_ECB_DEC) ? RUN_DEC
                     : (q_cmd.op == OP_MAC) ? RUN_MAC : RUN_ENC;
            case (q_cmd.op)
                OP_ECB_ENC, OP_ECB_DEC:
                    {n2_reg, n1_reg} <= swap_bytes(blk, bswap_reg);
                OP_GAMMA:   {n2_reg, n1_reg} <= {gn2, gn1};
                OP_MAC:
                begin
                    {n2_reg, n1_reg} <= mac_reg ^ (q_cmd.data & q_cmd.mask);
                    vb_reg <= q_cmd.active ? 4'd8 : 4'd0;
                end
                OP_GSYNC:   {n2_reg, n1_reg} <= {q_cmd.data[31:0], q_cmd.data[63:32]};
                default:    {n2_reg, n1_reg} <= sync_reg;
            endcase
        end
        else if (state_reg == ST_RUN)
        begin
            rnd_reg <= rnd_reg + 5'd1;
            n1_reg  <= x;
            n2_reg  <= n1_reg;
            if (last)
            begin
                case (cmd_reg.op)
                    OP_ECB_ENC, OP_ECB_DEC:
                        res_reg <= g & cmd_reg.mask;
                    OP_GAMMA, OP_CFB_ENC, OP_CFB_DEC:
                        res_reg <= (cmd_reg.data ^ g) & cmd_reg.mask;
                    OP_MAC:  res_reg <= g;
                    default: res_reg <= '0;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/gost_block_cipher_modes.sv =====
// Top level of the GOST 28147-89 cipher block.
//
// Usage: items arrive on valid/ready (opcode, block_in, byte_count, row_index).
// Results leave on out_valid/out_ready (block_out, valid_bytes), one per item,
// in order. Registers are written on cfg_valid/cfg_ready (always ready) with
// cfg_index and cfg_data; the user must write them only while the block is
// idle, as the block itself does not enforce this. A two-entry queue parts
// the front from the round engine, so items are taken while the engine works.
// Cipher items take 32 rounds, MAC items 16, one round a cycle in the shared
// round unit; the result is valid the cycle after the last round. Loads and
// ignored items give a zero result. The engine takes its next item only once
// the last result has left on out_valid/out_ready. Reset clears keys, sync and
// MAC registers and sets byte swap; the S-box is undefined until loaded. When
// out_ready is low the result holds, the engine waits, and the queue fills and
// then drops ready.
`default_nettype none
module gost_block_cipher_modes
    import gost_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             ready,
    input  wire logic [3:0]  opcode,
    input  wire logic [63:0] block_in,
    input  wire logic [3:0]  byte_count,
    input  wire logic [2:0]  row_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      block_out,
    output logic [3:0]       valid_bytes,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    gost_front u_front (
        .clk, .rst_n, .valid, .ready, .opcode, .block_in, .byte_count, .row_index,
        .q_valid, .q_ready, .q_cmd
    );

    gost_back u_back (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .q_valid, .q_ready, .q_cmd, .out_valid, .out_ready, .block_out, .valid_bytes
    );
endmodule
`default_nettype wire

// ===== src/gost_checker.sv =====
// Port-level checks for the GOST cipher block, bound to the top level.
`default_nettype none
module gost_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] block_out,
    input wire logic [3:0]  valid_bytes,
    input wire logic        cfg_ready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(block_out))
        else $error("result dropped while stalled");
    a_vb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> valid_bytes <= 4'd8)
        else $error("valid_bytes out of range");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_bytes == 4'd0 |-> block_out == 64'd0)
        else $error("nonzero data with no bytes");
endmodule

bind gost_block_cipher_modes gost_checker u_checker (
    .clk, .rst_n, .out_valid, .out_ready, .block_out, .valid_bytes, .cfg_ready
);
`default_nettype wire

// ===== tb/gost_block_cipher_modes_test.sv =====
// Self-checking testbench for the GOST 28147-89 cipher block: directed and random items.
`default_nettype none
module gost_block_cipher_modes_test;
    import gost_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [63:0] block_in;
    logic [3:0]  byte_count;
    logic [2:0]  row_index;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] block_out;
    logic [3:0]  valid_bytes;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    gost_block_cipher_modes uut (
        .clk(clk), .rst_n(rst_n),
        .valid(valid), .ready(ready),
        .opcode(opcode), .block_in(block_in), .byte_count(byte_count),
        .row_index(row_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .block_out(block_out), .valid_bytes(valid_bytes),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state
    logic [63:0] key_reg [4];
    logic        swap_en;
    logic [7:0]  fill_byte;
    logic [63:0] sbox [8];
    logic [63:0] counter_reg;
    logic [63:0] mac_reg;

    logic [63:0] want_block [$];
    logic [3:0]  want_bytes [$];

    int fail_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;

    always #5 clk = ~clk;

    function automatic logic [31:0] kw(input int i);
        logic [63:0] r;
        r = key_reg[(i >> 1) & 3];
        return (i & 1) ? r[63:32] : r[31:0];
    endfunction

    function automatic logic [31:0] gost_round(input logic [31:0] n1, input logic [31:0] k);
        logic [31:0] s;
        logic [31:0] t;
        logic [3:0]  v;
        s = n1 + k;
        t = '0;
        for (int j = 0; j < 8; j++)
        begin
            v = s[4*j +: 4];
            t[4*j +: 4] = sbox[j][4*v +: 4];
        end
        return {t[20:0], t[31:21]};
    endfunction

    function automatic logic [63:0] run_cipher(input logic [63:0] blk, input run_t run);
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] s;
        int nr;
        int ki;
        n1 = blk[31:0];
        n2 = blk[63:32];
        nr = (run == RUN_MAC) ? 16 : 32;
        for (int r = 0; r < nr; r++)
        begin
            if (run == RUN_ENC)
                ki = (r < 24) ? (r & 7) : (31 - r);
            else if (run == RUN_DEC)
                ki = (r < 8) ? r : (7 - (r & 7));
            else
                ki = r & 7;
            s = n2 ^ gost_round(n1, kw(ki));
            if (run != RUN_MAC && r == 31)
                n2 = s;
            else
            begin
                n2 = n1;
                n1 = s;
            end
        end
        return {n2, n1};
    endfunction

    function automatic logic [31:0] rev32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [63:0] order_bytes(input logic [63:0] b);
        return swap_en ? {rev32(b[63:32]), rev32(b[31:0])} : b;
    endfunction

    // Advance predictor state by one item and queue its result
    task automatic predict_item(input logic [3:0] op, input logic [63:0] data,
                                input logic [3:0] cnt_in, input logic [2:0] row);
        logic [63:0] m;
        logic [63:0] res;
        logic [63:0] g;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [3:0]  vb;
        int cnt;
        cnt = (cnt_in > 8) ? 8 : cnt_in;
        m = (cnt >= 8) ? '1 : ((64'd1 << (8 * cnt)) - 64'd1);
        res = '0;
        vb = '0;
        if (op <= OP_MAC && cnt != 0)
        begin
            vb = 4'(cnt);
            if (op == OP_ECB_ENC || op == OP_ECB_DEC)
            begin
                g = (data & m) | ({8{fill_byte}} & ~m);
                res = order_bytes(run_cipher(order_bytes(g),
                      (op == OP_ECB_ENC) ? RUN_ENC : RUN_DEC)) & m;
            end
            else if (op == OP_GAMMA)
            begin
                n1 = counter_reg[31:0] + C0;
                n2 = counter_reg[63:32] + C1;
                if (n2 < counter_reg[63:32])
                    n2 = n2 + 1;
                counter_reg = {n2, n1};
                res = (data ^ order_bytes(run_cipher(counter_reg, RUN_ENC))) & m;
            end
            else if (op == OP_CFB_ENC || op == OP_CFB_DEC)
            begin
                g = order_bytes(run_cipher(counter_reg, RUN_ENC));
                res = (data ^ g) & m;
                g = (g & ~m) | ((op == OP_CFB_ENC) ? res : (data & m));
                counter_reg = order_bytes(g);
            end
            else
            begin
                mac_reg = run_cipher(mac_reg ^ (data & m), RUN_MAC);
                res = order_bytes(mac_reg);
                vb = 4'd8;
            end
        end
        else if (op == OP_GSYNC)
            counter_reg = run_cipher({data[31:0], data[63:32]}, RUN_ENC);
        else if (op == OP_CSYNC)
            counter_reg = {data[31:0], data[63:32]};
        else if (op == OP_MAC_INIT)
            mac_reg = data;
        else if (op == OP_SBOX_ROW)
            sbox[row] = data;
        want_block.push_back(res);
        want_bytes.push_back(vb);
    endtask

    task automatic send_item(input logic [3:0] op, input logic [63:0] data,
                             input logic [3:0] cnt, input logic [2:0] row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            valid <= 1'b0;
            @(negedge clk);
        end
        valid <= 1'b1;
        opcode <= op;
        block_in <= data;
        byte_count <= cnt;
        row_index <= row;
        predict_item(op, data, cnt, row);
        @(posedge clk);
        while (!ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        valid <= 1'b0;
        while (want_block.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_KEY01: key_reg[0] = value;
            REG_KEY23: key_reg[1] = value;
            REG_KEY45: key_reg[2] = value;
            REG_KEY67: key_reg[3] = value;
            REG_BSWAP: swap_en = value[0];
            REG_PAD:   fill_byte = value[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic load_sbox_random();
        for (int r = 0; r < 8; r++)
            send_item(OP_SBOX_ROW, rand64(), 4'($urandom_range(15)), 3'(r));
    endtask

    task automatic test_directed();
        // load S-box with extremes first, then real content
        for (int r = 0; r < 8; r++)
            send_item(OP_SBOX_ROW, (r == 0) ? 64'h0 : ((r == 1) ? '1 : rand64()), 4'd8, 3'(r));
        send_item(OP_ECB_ENC, 64'h0, 4'd8, 3'd0);
        send_item(OP_ECB_DEC, '1, 4'd8, 3'd7);
        load_sbox_random();
        send_item(OP_ECB_ENC, rand64(), 4'd1, 3'd0);
        send_item(OP_ECB_DEC, rand64(), 4'd5, 3'd0);
        send_item(OP_ECB_ENC, rand64(), 4'd0, 3'd0);
        send_item(OP_ECB_ENC, rand64(), 4'd15, 3'd0);
        send_item(OP_GSYNC, rand64(), 4'd8, 3'd0);
        send_item(OP_GAMMA, rand64(), 4'd8, 3'd0);
        send_item(OP_GAMMA, rand64(), 4'd3, 3'd0);
        send_item(OP_CSYNC, '1, 4'd8, 3'd0);
        send_item(OP_CFB_ENC, rand64(), 4'd8, 3'd0);
        send_item(OP_CFB_DEC, rand64(), 4'd2, 3'd0);
        send_item(OP_MAC_INIT, 64'h0, 4'd8, 3'd0);
        send_item(OP_MAC, rand64(), 4'd8, 3'd0);
        send_item(OP_MAC, rand64(), 4'd4, 3'd0);
        send_item(4'd10, rand64(), 4'd8, 3'd0);
        send_item(4'd15, rand64(), 4'd8, 3'd0);
        drain_results();
    endtask

    task automatic test_gamma_wrap();
        // counter halves near wrap exercise the end-around carry
        send_item(OP_CSYNC, 64'hFFFF_FFFE_FFFF_FFFF, 4'd8, 3'd0);
        send_item(OP_GAMMA, rand64(), 4'd8, 3'd0);
        send_item(OP_GAMMA, rand64(), 4'd8, 3'd0);
        drain_results();
    endtask

    task automatic random_item();
        int pick;
        logic [3:0] op;
        pick = $urandom_range(99);
        if (pick < 3)
            op = OP_SBOX_ROW;
        else if (pick < 8)
            op = 4'($urandom_range(OP_GSYNC, OP_MAC_INIT));
        else if (pick < 10)
            op = 4'($urandom_range(10, 15));
        else
            op = 4'($urandom_range(OP_ECB_ENC, OP_MAC));
        send_item(op, rand64(),
                  ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8)),
                  3'($urandom_range(7)));
    endtask

    task automatic test_random_phase(input int n_items);
        write_reg(REG_KEY01, rand64());
        write_reg(REG_KEY23, rand64());
        write_reg(REG_KEY45, rand64());
        write_reg(REG_KEY67, rand64());
        write_reg(REG_BSWAP, 64'($urandom_range(1)));
        write_reg(REG_PAD, 64'($urandom_range(255)));
        for (int i = 0; i < n_items; i++)
            random_item();
        drain_results();
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (want_block.size() == 0)
            begin
                $error("unexpected item: block_out %h valid_bytes %0d", block_out, valid_bytes);
                fail_count++;
            end
            else
            begin
                if (block_out !== want_block[0])
                begin
                    $error("block_out expected %h actual %h", want_block[0], block_out);
                    fail_count++;
                end
                if (valid_bytes !== want_bytes[0])
                begin
                    $error("valid_bytes expected %0d actual %0d", want_bytes[0], valid_bytes);
                    fail_count++;
                end
                void'(want_block.pop_front());
                void'(want_bytes.pop_front());
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        valid = 1'b0;
        opcode = '0;
        block_in = '0;
        byte_count = '0;
        row_index = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 13;
        recv_idle_pct = 77;
        for (int i = 0; i < 4; i++)
            key_reg[i] = '0;
        for (int i = 0; i < 8; i++)
            sbox[i] = '0;
        swap_en = 1'b1;
        fill_byte = '0;
        counter_reg = '0;
        mac_reg = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        write_reg(REG_KEY01, '1);
        write_reg(REG_KEY67, 64'h0);
        write_reg(REG_BSWAP, 64'd0);
        write_reg(REG_PAD, 64'hFF);
        test_gamma_wrap();
        send_idle_pct = 13;
        recv_idle_pct = 77;
        test_random_phase(160);
        send_idle_pct = 77;
        recv_idle_pct = 13;
        test_random_phase(160);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(180);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
src/gost_pkg.sv
src/gost_front.sv
src/gost_back.sv
src/gost_block_cipher_modes.sv
src/gost_checker.sv
tb/gost_block_cipher_modes_test.sv
